/* rtl/assert_macros.svh */
// Assertion macros used by the checker file rme_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge, disabled during reset.
`define AST_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define AST_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/rme_pkg.sv */
// Shared types and constants for the rotation-matrix-to-Euler block.
// No dependencies.
package rme_pkg;
  localparam int MaxStages  = 24;
  localparam int PreShift   = 8;
  localparam int CordW      = 28;
  localparam int AngW       = 24;
  localparam int SumW       = 33;
  localparam int SqrtW      = 17;
  localparam int SqrtSteps  = 17;
  localparam logic signed [AngW-1:0] HalfPi = 24'sd1647099;
  localparam int AngleLimit = 25736;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [15:0] q13_t;

  // One vectoring operand set travelling through the CORDIC cells.
  typedef struct packed {
    logic                    zero;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
  } cord_t;

  function automatic logic signed [AngW-1:0] atan_entry(input int i);
    logic signed [AngW-1:0] t;
    case (i)
      0: t = 24'sd823550;   1: t = 24'sd486170;  2: t = 24'sd256879;
      3: t = 24'sd130396;   4: t = 24'sd65451;   5: t = 24'sd32757;
      6: t = 24'sd16383;    7: t = 24'sd8192;    8: t = 24'sd4096;
      9: t = 24'sd2048;    10: t = 24'sd1024;   11: t = 24'sd512;
      12: t = 24'sd256;    13: t = 24'sd128;    14: t = 24'sd64;
      15: t = 24'sd32;     16: t = 24'sd16;     17: t = 24'sd8;
      18: t = 24'sd4;      19: t = 24'sd2;      20: t = 24'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Pre-rotate into the right half plane.
  function automatic cord_t cord_load(input logic signed [SqrtW:0] yi,
                                      input logic signed [SqrtW:0] xi);
    cord_t c;
    logic signed [CordW-1:0] xs, ys;
    xs = CordW'(xi) <<< PreShift;
    ys = CordW'(yi) <<< PreShift;
    c.zero = (xi == 0) && (yi == 0);
    c.x = xs; c.y = ys; c.z = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        c.x = ys; c.y = -xs; c.z = HalfPi;
      end else begin
        c.x = -ys; c.y = xs; c.z = -HalfPi;
      end
    end
    return c;
  endfunction

  function automatic q13_t cord_out(input cord_t c);
    logic signed [AngW-1:0] r;
    r = (c.z + AngW'(64)) >>> 7;
    if (c.zero) r = '0;
    else if (r > AngW'(AngleLimit)) r = AngW'(AngleLimit);
    else if (r < -AngW'(AngleLimit)) r = -AngW'(AngleLimit);
    return r[15:0];
  endfunction
endpackage

/* rtl/rme_if.sv */
// Valid/ready channel interface carrying a packed payload.
// No dependencies.
interface rme_if #(parameter int W = 8) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rme_sqrt_cell.sv */
// One restoring square-root step: one result bit per cell.
// Depends on rme_pkg.
module rme_sqrt_cell #(parameter int STEP = 0) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rme_pkg::SumW-1:0]      rem_in,
  input  logic [rme_pkg::SqrtW-1:0]     root_in,
  output logic [rme_pkg::SumW-1:0]      rem_out,
  output logic [rme_pkg::SqrtW-1:0]     root_out
);
  import rme_pkg::*;
  localparam int Sh = 2 * (SqrtSteps - 1 - STEP);
  logic [SumW+1:0] trial;
  logic [SumW+1:0] cmp;
  always_comb begin
    trial = ({2'b0, SumW'(root_in)} << (Sh + 2)) | ((SumW+2)'(1) << Sh);
    cmp   = {2'b0, rem_in};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (cmp >= trial) begin
        rem_out  <= SumW'(cmp - trial);
        root_out <= {root_in[SqrtW-2:0], 1'b1};
      end else begin
        rem_out  <= rem_in;
        root_out <= {root_in[SqrtW-2:0], 1'b0};
      end
    end
  end
endmodule

/* rtl/rme_cordic_cell.sv */
// One vectoring CORDIC micro-rotation stage.
// Depends on rme_pkg.
module rme_cordic_cell #(parameter int STEP = 0) (
  input  logic           clk,
  input  logic           en,
  input  rme_pkg::cord_t cin,
  output rme_pkg::cord_t cout
);
  import rme_pkg::*;
  logic signed [CordW-1:0] xs, ys;
  logic signed [AngW-1:0]  t;
  always_comb begin
    xs = cin.x >>> STEP;
    ys = cin.y >>> STEP;
    t  = atan_entry(STEP);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cout.zero <= cin.zero;
      if (cin.y >= 0) begin
        cout.x <= cin.x + ys; cout.y <= cin.y - xs; cout.z <= cin.z + t;
      end else begin
        cout.x <= cin.x - ys; cout.y <= cin.y + xs; cout.z <= cin.z - t;
      end
    end
  end
endmodule

/* rtl/rotation_matrix_to_euler.sv */
// Rotation matrix (Q1.14) to Z-Y-X Euler angles (Q3.13), pipelined.
// Depends on rme_pkg, rme_if, rme_sqrt_cell, rme_cordic_cell.
//
//  channel  | dir | payload
//  in_ch    | in  | r00 r10 r20 r21 r22 r11 r12 (16b signed each)
//  out_ch   | out | roll_angle pitch_angle yaw_angle gimbal_lock
//  apb      | in  | singular_threshold at address 0
//
// One matrix per cycle while the output is not stalled; the pipe is 1 input register + 17 sqrt
// cells + 1 load + CORDIC_STEPS cells (capped at MaxStages) + 1 output register.
// The whole pipe advances only when the output stage is empty or being taken.
// Synchronous reset clears valid bits and sets the threshold to 1.
module rotation_matrix_to_euler #(parameter int CORDIC_STEPS = 16) (
  input  logic        clk,
  input  logic        rst,
  rme_if.sink         in_ch,
  rme_if.source       out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rme_pkg::*;
  localparam int Steps = (CORDIC_STEPS < MaxStages) ? CORDIC_STEPS : MaxStages;
  localparam int Depth = 1 + SqrtSteps + 1 + Steps + 1;

  logic [7:0] singular_threshold;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {24'd0, singular_threshold} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) singular_threshold <= 8'd1;
    else if (psel && penable && pwrite && paddr == 2'd0)
      singular_threshold <= pwdata[7:0];
  end

  logic adv;
  logic [Depth-1:0] vld;
  assign adv = !vld[Depth-1] || out_ch.ready;
  assign in_ch.ready = adv;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Depth-2:0], in_ch.valid};
  end

  // stage 0: squares and operand capture
  q14_t d00, d10, d20, d21, d22, d11, d12;
  logic [SumW-1:0] sum0;
  always_ff @(posedge clk) begin
    if (adv) begin
      {d00, d10, d20, d21, d22, d11, d12} <= in_ch.data;
    end
  end
  logic signed [31:0] sq00, sq10;
  always_comb begin
    sq00 = d00 * d00;
    sq10 = d10 * d10;
  end

  // carry the operands alongside the sqrt cells
  logic [SumW-1:0]  rem  [SqrtSteps+1];
  logic [SqrtW-1:0] root [SqrtSteps+1];
  q14_t c00 [SqrtSteps+1], c10 [SqrtSteps+1], c20 [SqrtSteps+1];
  q14_t c21 [SqrtSteps+1], c22 [SqrtSteps+1], c11 [SqrtSteps+1], c12 [SqrtSteps+1];
  assign sum0 = SumW'(unsigned'(sq00)) + SumW'(unsigned'(sq10));
  assign rem[0] = sum0;
  assign root[0] = '0;
  assign c00[0] = d00; assign c10[0] = d10; assign c20[0] = d20;
  assign c21[0] = d21; assign c22[0] = d22; assign c11[0] = d11; assign c12[0] = d12;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    rme_sqrt_cell #(.STEP(g)) u_cell (
      .clk(clk), .en(adv), .rem_in(rem[g]), .root_in(root[g]),
      .rem_out(rem[g+1]), .root_out(root[g+1]));
    always_ff @(posedge clk) begin
      if (adv) begin
        c00[g+1] <= c00[g]; c10[g+1] <= c10[g]; c20[g+1] <= c20[g];
        c21[g+1] <= c21[g]; c22[g+1] <= c22[g]; c11[g+1] <= c11[g];
        c12[g+1] <= c12[g];
      end
    end
  end

  // load stage: lock decision and pre-rotation
  logic [SqrtW-1:0] sy;
  logic             lock_now;
  assign sy = root[SqrtSteps];
  assign lock_now = sy < SqrtW'(singular_threshold);
  cord_t roll_c [Steps+1], pitch_c [Steps+1], yaw_c [Steps+1];
  logic  lock_p [Steps+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      lock_p[0]  <= lock_now;
      pitch_c[0] <= cord_load(-(SqrtW+1)'(c20[SqrtSteps]), {1'b0, sy});
      if (lock_now)
        roll_c[0] <= cord_load(-(SqrtW+1)'(c12[SqrtSteps]), (SqrtW+1)'(c11[SqrtSteps]));
      else
        roll_c[0] <= cord_load((SqrtW+1)'(c21[SqrtSteps]), (SqrtW+1)'(c22[SqrtSteps]));
      yaw_c[0] <= cord_load((SqrtW+1)'(c10[SqrtSteps]), (SqrtW+1)'(c00[SqrtSteps]));
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_cord
    rme_cordic_cell #(.STEP(s)) u_roll  (.clk(clk), .en(adv), .cin(roll_c[s]),
                                         .cout(roll_c[s+1]));
    rme_cordic_cell #(.STEP(s)) u_pitch (.clk(clk), .en(adv), .cin(pitch_c[s]),
                                         .cout(pitch_c[s+1]));
    rme_cordic_cell #(.STEP(s)) u_yaw   (.clk(clk), .en(adv), .cin(yaw_c[s]),
                                         .cout(yaw_c[s+1]));
    always_ff @(posedge clk) begin
      if (adv) lock_p[s+1] <= lock_p[s];
    end
  end

  // output register; holds while stalled
  logic [48:0] res;
  always_ff @(posedge clk) begin
    if (adv) begin
      res <= {cord_out(roll_c[Steps]), cord_out(pitch_c[Steps]),
              lock_p[Steps] ? 16'd0 : cord_out(yaw_c[Steps]), lock_p[Steps]};
    end
  end
  assign out_ch.valid = vld[Depth-1];
  assign out_ch.data  = res;
endmodule

/* rtl/rme_checker.sv */
// Port-level checker for the Euler block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module rme_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [48:0] out_data,
  input logic [31:0] prdata,
  input logic        pready
);
  `AST_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `AST_IMP(a_stall, clk, rst, out_valid && !out_ready, !in_ready)
  `AST_IMP(a_yaw0, clk, rst, out_valid && out_data[0], out_data[16:1] == 16'd0)
  `AST_IMP(a_rdy, clk, rst, !out_valid, in_ready && pready)
endmodule

bind rotation_matrix_to_euler rme_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
  .prdata(prdata), .pready(pready));
